// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

    localparam int FRAMES_DEF    = 1024;
    localparam int WORD_BITS_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int FRAME_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FWR,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bfa_ram.sv =====
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bfa_word_find.sv =====
module bfa_word_find #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 11,
    parameter int BW        = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [PW-1:0]        base,
    input  logic [PW-1:0]        limit,
    output logic                 found,
    output logic [BW-1:0]        bit_pos
);

    logic [WORD_BITS-1:0] free_bits;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !word[b] && ((base + PW'(b)) < limit);
        end
    end

    // Lowest free bit wins, so the loop runs from the top down.
    always_comb
    begin
        found   = 1'b0;
        bit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                found   = 1'b1;
                bit_pos = BW'(b);
            end
        end
    end

endmodule

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// Bitmap frame allocator with one used bit per frame, kept in a word-wide RAM.
// The slave stream carries requests: tuser holds the mode (allocate, free,
// peek) and tdata the frame index for a free. Every request transaction gives
// exactly one result transaction on the master stream: tdata holds the frame,
// tuser the status. cfg_we and cfg_wdata write the number of managed frames.
// Allocate and peek scan the bitmap one word per cycle through a single
// masked priority finder and stop at the word that holds the lowest free
// frame, or at the last word in range. A free request splits the index into
// word and bit, reads the word and writes it back.
// The block holds one request at a time and is ready again once the result
// is in the output register. If the receiver stalls, a finished result waits
// in the DONE state until the output register is free.
// After reset a clearing pass writes zeros into all MAP_WORDS words, one
// word per cycle; s_axis_tready stays low until that pass is through.
module bitmap_frame_allocator_unit #(
    parameter int FRAMES    = bfa_pkg::FRAMES_DEF,
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfa_pkg::COUNT_W-1:0]   cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [9:0] frame_index
    input  logic [bfa_pkg::MODE_W-1:0]    s_axis_tuser,  // [1:0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [9:0] frame
    output logic [bfa_pkg::STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

    import bfa_pkg::*;

    localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int PW_RAW    = $clog2(FRAMES + WORD_BITS + 1);
    localparam int PW        = (PW_RAW > COUNT_W) ? PW_RAW : COUNT_W;

    localparam logic [PW-1:0] FRAMES_PW = PW'(FRAMES);
    localparam logic [PW-1:0] WORD_PW   = PW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [AW-1:0]         word_reg, word_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic                  alloc_reg, alloc_next;
    logic [FRAME_W-1:0]    res_frame_reg, res_frame_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]    out_frame_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [PW-1:0]         count_ext;
    logic [PW-1:0]         live_count;
    logic [PW-1:0]         idx_ext;
    logic [AW-1:0]         idx_word;
    logic [PW-1:0]         idx_bit;
    logic [PW-1:0]         pos_step;
    logic                  find_found;
    logic [BW-1:0]         find_pos;
    logic [PW-1:0]         hit_frame;
    logic                  in_fire;
    logic                  out_free;
    logic                  scan_last;

    assign count_ext  = PW'(count_reg);
    assign live_count = (count_ext > FRAMES_PW) ? FRAMES_PW : count_ext;
    assign idx_ext    = PW'(s_axis_tdata[FRAME_W-1:0]);
    assign idx_word   = AW'(idx_ext >> BW);
    assign idx_bit    = PW'(idx_ext[BW-1:0]);
    assign pos_step   = pos_reg + WORD_PW;
    assign hit_frame  = pos_reg + PW'(find_pos);
    assign scan_last  = (pos_step >= live_count) || (word_reg == LAST_WORD);
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_frame_reg);
    assign m_axis_tuser  = out_status_reg;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_word_find #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW),
        .BW        (BW)
    ) u_find (
        .word    (ram_rdata),
        .base    (pos_reg),
        .limit   (live_count),
        .found   (find_found),
        .bit_pos (find_pos)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_axis_tuser)
                        MODE_ALLOC, MODE_PEEK: state_next = ST_SCAN;
                        MODE_FREE:
                        begin
                            state_next = (idx_ext < live_count) ? ST_FWR : ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (find_found || scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FWR:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        word_next       = word_reg;
        pos_next        = pos_reg;
        alloc_next      = alloc_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = '0;
        ram_raddr       = word_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                word_next = word_reg + AW'(1);
            end
            ST_IDLE:
            begin
                word_next       = (s_axis_tuser == MODE_FREE) ? idx_word : '0;
                ram_raddr       = (s_axis_tuser == MODE_FREE) ? idx_word : '0;
                res_frame_next  = '0;
                res_status_next = STATUS_OK;
                alloc_next      = (s_axis_tuser == MODE_ALLOC);
                pos_next        = (s_axis_tuser == MODE_FREE) ? idx_bit : '0;
                if (in_fire && s_axis_tuser == MODE_FREE && idx_ext >= live_count)
                begin
                    res_status_next = STATUS_RANGE;
                end
            end
            ST_SCAN:
            begin
                if (find_found)
                begin
                    res_frame_next = hit_frame[FRAME_W-1:0];
                    ram_we         = alloc_reg;
                    ram_wdata      = ram_rdata | (WORD_BITS'(1) << find_pos);
                end
                else if (scan_last)
                begin
                    res_status_next = STATUS_NONE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                    ram_raddr = word_reg + AW'(1);
                    pos_next  = pos_step;
                end
            end
            ST_FWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << pos_reg[BW-1:0]);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        alloc_reg      <= alloc_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_frame_reg  <= res_frame_reg;
            out_status_reg <= res_status_reg;
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished request");

    a_peek_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_SCAN) |-> alloc_reg)
        else $error("bitmap written during a peek");

    a_free_bit_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FWR |-> pos_reg < WORD_PW)
        else $error("free bit position beyond the word");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");

endmodule
